FILE: rtl/opnc_pkg.sv
package opnc_pkg;

    localparam int MAX_DEGREE = 16;
    // index width for the recurrence tables and the degree step counter
    localparam int IDX_W      = $clog2(MAX_DEGREE);
    localparam int CFG_IDX_W  = 3;

    localparam logic [63:0] Q_ONE   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_LOAD_W = 2'd2,
        OP_EVAL   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED     = 3'd0,
        CFG_DEGREE      = 3'd1,
        CFG_OFFSET      = 3'd2,
        CFG_GAIN        = 3'd3,
        CFG_BASE_OFFSET = 3'd4,
        CFG_BASE_SLOPE  = 3'd5
    } cfg_idx_t;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MS_GAIN  = 3'd0,
        MS_SLOPE = 3'd1,
        MS_T1    = 3'd2,
        MS_T2    = 3'd3,
        MS_W     = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic             take;
        logic             mul_start;
        mul_sel_t         mul_sel;
        logic             a_first;
        logic [IDX_W-1:0] j;
        logic             diff_en;
        logic             out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic             mul_done;
        logic             enabled;
        logic [IDX_W-1:0] last_j;
    } dp_status_t;

endpackage

FILE: rtl/opnc_mul.sv
module opnc_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] prod,
    output logic        ovf
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_MAG  = 5'b00010,
        M_PP   = 5'b00100,
        M_RND  = 5'b01000,
        M_SAT  = 5'b10000
    } mul_state_t;

    localparam logic [63:0] SAT_MIN_L = opnc_pkg::SAT_MIN;
    localparam logic [63:0] SAT_MAX_L = opnc_pkg::SAT_MAX;

    mul_state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       done_reg, done_next;

    logic [63:0]  a_reg, b_reg;
    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   shift_reg;
    logic [127:0] acc_reg;
    logic [127:0] rnd_reg;
    logic [63:0]  prod_reg;
    logic         ovf_reg;

    logic [31:0]  ha, hb;
    logic [63:0]  pp_full;
    logic [1:0]   shift_cur;
    logic [127:0] pp_shifted;
    logic [63:0]  r_mag;
    logic [63:0]  limit;
    logic         sat_hit;
    logic [63:0]  sat_res;

    // step 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
    assign ha        = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign hb        = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp_full   = ha * hb;
    assign shift_cur = {1'b0, step_reg[0]} + {1'b0, step_reg[1]};

    always_comb
    begin
        unique case (shift_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    assign r_mag   = rnd_reg[95:32];
    assign limit   = neg_reg ? SAT_MIN_L : SAT_MAX_L;
    assign sat_hit = (|rnd_reg[127:96]) || (r_mag > limit);
    assign sat_res = sat_hit ? limit : (neg_reg ? (64'd0 - r_mag) : r_mag);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_MAG;
                end
            end
            M_MAG:
            begin
                step_next  = 3'd0;
                state_next = M_PP;
            end
            M_PP:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    state_next = M_RND;
                end
            end
            M_RND:
            begin
                state_next = M_SAT;
            end
            M_SAT:
            begin
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            step_reg  <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        if (state_reg == M_MAG)
        begin
            ma_reg  <= a_reg[63] ? (64'd0 - a_reg) : a_reg;
            mb_reg  <= b_reg[63] ? (64'd0 - b_reg) : b_reg;
            neg_reg <= a_reg[63] ^ b_reg[63];
            acc_reg <= '0;
        end
        if (state_reg == M_PP)
        begin
            // multiply one half pair, add the previous partial product
            if (step_reg != 3'd4)
            begin
                pp_reg    <= pp_full;
                shift_reg <= shift_cur;
            end
            if (step_reg != 3'd0)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
        if (state_reg == M_RND)
        begin
            rnd_reg <= acc_reg + 128'h8000_0000;
        end
        if (state_reg == M_SAT)
        begin
            prod_reg <= sat_res;
            ovf_reg  <= sat_hit;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;
    assign ovf  = ovf_reg;

endmodule

FILE: rtl/opnc_datapath.sv
module opnc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  opnc_pkg::dp_cmd_t                     cmd,
    output opnc_pkg::dp_status_t                  status,
    input  logic [1:0]                            op,
    input  logic [3:0]                            table_index,
    input  logic signed [63:0]                    table_value,
    input  logic [23:0]                           position,
    input  logic                                  cfg_write,
    input  logic [opnc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [63:0]                           cfg_data,
    output logic signed [63:0]                    corrected,
    output logic                                  overflow
);

    localparam int IW = opnc_pkg::IDX_W;
    localparam int MD = opnc_pkg::MAX_DEGREE;

    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            return {1'b1, a[63] ? opnc_pkg::SAT_MIN : opnc_pkg::SAT_MAX};
        end
        return {1'b0, s};
    endfunction

    function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
        begin
            return {1'b1, a[63] ? opnc_pkg::SAT_MIN : opnc_pkg::SAT_MAX};
        end
        return {1'b0, s};
    endfunction

    logic [63:0] a_mem [MD];
    logic [63:0] b_mem [MD-1];
    logic [63:0] w_mem [MD-1];

    logic        enabled_reg;
    logic [4:0]  degree_reg;
    logic [63:0] offset_reg, gain_reg, base_offset_reg, base_slope_reg;

    logic [63:0] a_rd_reg, b_rd_reg, w_rd_reg;
    logic [23:0] pos_reg;
    logic [63:0] x_reg, acc_reg, p_prev_reg, p_cur_reg, p_next_reg, t1_reg, diff_reg;
    logic        ovf_reg;
    logic [63:0] corrected_reg;
    logic        overflow_reg;

    logic [IW-1:0] a_addr;
    logic [63:0]   pos_q;
    logic [63:0]   mul_a, mul_b;
    logic          mul_done;
    logic [63:0]   mul_prod;
    logic          mul_ovf;
    logic [64:0]   add_gain, add_slope, sub_a, sub_t2, add_w;
    logic          take_eval;

    assign take_eval = cmd.take && (op == opnc_pkg::OP_EVAL);
    assign a_addr    = cmd.a_first ? '0 : IW'(cmd.j + IW'(1));

    // (position + 1 channel) in Q16.8 placed at Q32.32
    assign pos_q = {15'd0, {1'b0, pos_reg} + 25'd256, 24'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            degree_reg      <= 5'd2;
            offset_reg      <= '0;
            gain_reg        <= '0;
            base_offset_reg <= '0;
            base_slope_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                opnc_pkg::CFG_ENABLED:     enabled_reg     <= cfg_data[0];
                opnc_pkg::CFG_DEGREE:      degree_reg      <= cfg_data[4:0];
                opnc_pkg::CFG_OFFSET:      offset_reg      <= cfg_data;
                opnc_pkg::CFG_GAIN:        gain_reg        <= cfg_data;
                opnc_pkg::CFG_BASE_OFFSET: base_offset_reg <= cfg_data;
                opnc_pkg::CFG_BASE_SLOPE:  base_slope_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // tables: written by load transactions; reads are registered, valid in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (cmd.take && op == opnc_pkg::OP_LOAD_A && int'(table_index) < MD)
        begin
            a_mem[IW'(table_index)] <= table_value;
        end
        if (cmd.take && op == opnc_pkg::OP_LOAD_B && int'(table_index) < MD - 1)
        begin
            b_mem[IW'(table_index)] <= table_value;
        end
        if (cmd.take && op == opnc_pkg::OP_LOAD_W && int'(table_index) < MD - 1)
        begin
            w_mem[IW'(table_index)] <= table_value;
        end
        a_rd_reg <= a_mem[a_addr];
        b_rd_reg <= b_mem[cmd.j];
        w_rd_reg <= w_mem[cmd.j];
    end

    always_comb
    begin
        status.mul_done = mul_done;
        status.enabled  = enabled_reg;
        // clamp degree to the supported range
        if (degree_reg < 5'd2)
        begin
            status.last_j = '0;
        end
        else if (int'(degree_reg) > MD)
        begin
            status.last_j = IW'(MD - 2);
        end
        else
        begin
            status.last_j = IW'(degree_reg - 5'd2);
        end
    end

    always_comb
    begin
        unique case (cmd.mul_sel)
            opnc_pkg::MS_GAIN:
            begin
                mul_a = pos_q;
                mul_b = gain_reg;
            end
            opnc_pkg::MS_SLOPE:
            begin
                mul_a = base_slope_reg;
                mul_b = x_reg;
            end
            opnc_pkg::MS_T1:
            begin
                mul_a = diff_reg;
                mul_b = p_cur_reg;
            end
            opnc_pkg::MS_T2:
            begin
                mul_a = b_rd_reg;
                mul_b = p_prev_reg;
            end
            opnc_pkg::MS_W:
            begin
                mul_a = w_rd_reg;
                mul_b = p_next_reg;
            end
            default:
            begin
                mul_a = pos_q;
                mul_b = gain_reg;
            end
        endcase
    end

    opnc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .done  (mul_done),
        .prod  (mul_prod),
        .ovf   (mul_ovf)
    );

    always_comb
    begin
        add_gain  = sat_add(offset_reg, mul_prod);
        add_slope = sat_add(base_offset_reg, mul_prod);
        sub_a     = sat_sub(x_reg, a_rd_reg);
        sub_t2    = sat_sub(t1_reg, mul_prod);
        add_w     = sat_add(acc_reg, mul_prod);
    end

    always_ff @(posedge clk)
    begin
        if (take_eval)
        begin
            pos_reg <= position;
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        if (cmd.diff_en)
        begin
            diff_reg <= sub_a[63:0];
            ovf_reg  <= ovf_reg | sub_a[64];
        end
        if (mul_done)
        begin
            unique case (cmd.mul_sel)
                opnc_pkg::MS_GAIN:
                begin
                    x_reg   <= add_gain[63:0];
                    ovf_reg <= ovf_reg | mul_ovf | add_gain[64];
                end
                opnc_pkg::MS_SLOPE:
                begin
                    // baseline, then seed the recurrence with P0 and P1
                    acc_reg    <= add_slope[63:0];
                    p_prev_reg <= opnc_pkg::Q_ONE;
                    p_cur_reg  <= sub_a[63:0];
                    ovf_reg    <= ovf_reg | mul_ovf | add_slope[64] | sub_a[64];
                end
                opnc_pkg::MS_T1:
                begin
                    t1_reg  <= mul_prod;
                    ovf_reg <= ovf_reg | mul_ovf;
                end
                opnc_pkg::MS_T2:
                begin
                    p_next_reg <= sub_t2[63:0];
                    ovf_reg    <= ovf_reg | mul_ovf | sub_t2[64];
                end
                opnc_pkg::MS_W:
                begin
                    acc_reg    <= add_w[63:0];
                    p_prev_reg <= p_cur_reg;
                    p_cur_reg  <= p_next_reg;
                    ovf_reg    <= ovf_reg | mul_ovf | add_w[64];
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.out_load)
        begin
            corrected_reg <= acc_reg;
            overflow_reg  <= ovf_reg;
        end
    end

    assign corrected = corrected_reg;
    assign overflow  = overflow_reg;

endmodule

FILE: rtl/opnc_ctrl.sv
module opnc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             op,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output opnc_pkg::dp_cmd_t      cmd,
    input  opnc_pkg::dp_status_t   status
);

    localparam int IW = opnc_pkg::IDX_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_GAIN  = 9'b000000010,
        S_SLOPE = 9'b000000100,
        S_RD    = 9'b000001000,
        S_DIFF  = 9'b000010000,
        S_T1    = 9'b000100000,
        S_T2    = 9'b001000000,
        S_W     = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic          issued_reg, issued_next;
    logic [IW-1:0] j_reg, j_next;
    logic          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && out_stall;

        cmd.take      = 1'b0;
        cmd.mul_start = 1'b0;
        cmd.mul_sel   = opnc_pkg::MS_GAIN;
        cmd.a_first   = 1'b0;
        cmd.j         = j_reg;
        cmd.diff_en   = 1'b0;
        cmd.out_load  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.a_first = 1'b1;
                cmd.take    = in_valid;
                if (in_valid && op == opnc_pkg::OP_EVAL)
                begin
                    j_next     = '0;
                    state_next = status.enabled ? S_GAIN : S_FIN;
                end
            end
            S_GAIN:
            begin
                cmd.a_first   = 1'b1;
                cmd.mul_sel   = opnc_pkg::MS_GAIN;
                cmd.mul_start = !issued_reg;
                issued_next   = 1'b1;
                if (status.mul_done)
                begin
                    issued_next = 1'b0;
                    state_next  = S_SLOPE;
                end
            end
            S_SLOPE:
            begin
                cmd.a_first   = 1'b1;
                cmd.mul_sel   = opnc_pkg::MS_SLOPE;
                cmd.mul_start = !issued_reg;
                issued_next   = 1'b1;
                if (status.mul_done)
                begin
                    issued_next = 1'b0;
                    j_next      = '0;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                // let the table reads for this degree settle
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = S_T1;
            end
            S_T1:
            begin
                cmd.mul_sel   = opnc_pkg::MS_T1;
                cmd.mul_start = !issued_reg;
                issued_next   = 1'b1;
                if (status.mul_done)
                begin
                    issued_next = 1'b0;
                    state_next  = S_T2;
                end
            end
            S_T2:
            begin
                cmd.mul_sel   = opnc_pkg::MS_T2;
                cmd.mul_start = !issued_reg;
                issued_next   = 1'b1;
                if (status.mul_done)
                begin
                    issued_next = 1'b0;
                    state_next  = S_W;
                end
            end
            S_W:
            begin
                cmd.mul_sel   = opnc_pkg::MS_W;
                cmd.mul_start = !issued_reg;
                issued_next   = 1'b1;
                if (status.mul_done)
                begin
                    issued_next = 1'b0;
                    if (j_reg == status.last_j)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        j_next     = j_reg + IW'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/orthogonal_poly_nonlinearity_correct.sv
// Orthogonal-polynomial nonlinearity correction of a channel position.
// Input channel (in_valid / in_stall): one transaction per load or evaluate.
// Loads (op 0..2) write the a, b or weight table entry table_index; they
// produce no result. An evaluate (op 3) maps position to X, runs the
// three-term recurrence up to the configured degree and delivers one
// result transaction (corrected, overflow) on the output channel. Every
// multiply goes through one shared 64x64 unit built from four 32x32
// partial products, three multiplies per degree plus two for the X
// mapping and the baseline. A disabled evaluate skips the multiplies
// and delivers a zero result. One item is worked on at a time; in_stall
// is high while an evaluate runs.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver holds out_stall, the result and out_valid hold, and
// a following evaluate waits in its last step until the register is free.
// Configuration (cfg_write, cfg_index, cfg_data) is taken in any cycle.
// Reset clears control state and sets enabled 0, degree 2 and the other
// configuration registers 0; table contents are undefined until loaded.
module orthogonal_poly_nonlinearity_correct (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      op,
    input  logic [3:0]                      table_index,
    input  logic signed [63:0]              table_value,
    input  logic [23:0]                     position,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [63:0]              corrected,
    output logic                            overflow,
    input  logic                            cfg_write,
    input  logic [opnc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                     cfg_data
);

    opnc_pkg::dp_cmd_t    cmd;
    opnc_pkg::dp_status_t status;

    opnc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    opnc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .op          (op),
        .table_index (table_index),
        .table_value (table_value),
        .position    (position),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .corrected   (corrected),
        .overflow    (overflow)
    );

endmodule

FILE: rtl/opnc_checker.sv
module opnc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         op,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [63:0] corrected,
    input logic               overflow
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(corrected) && $stable(overflow))
        else $error("stalled result changed");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == opnc_pkg::OP_EVAL |=> in_stall)
        else $error("input taken again right after an evaluate");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op != opnc_pkg::OP_EVAL |=> !in_stall)
        else $error("load transaction left the block busy");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op != opnc_pkg::OP_EVAL && !out_valid |=> !out_valid)
        else $error("load transaction produced a result");

endmodule

bind orthogonal_poly_nonlinearity_correct opnc_checker u_opnc_checker (.*);
